[rtl/obstacle_detect_brake_controller_macros.svh]
// Assertion macros used by the obstacle detect brake controller FSM.
`ifndef OBSTACLE_DETECT_BRAKE_CONTROLLER_MACROS_SVH
`define OBSTACLE_DETECT_BRAKE_CONTROLLER_MACROS_SVH

// Property checked at every edge outside reset.
`define ODBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent this cycle implies consequent next cycle.
`define ODBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/odbc_pkg.sv]
package odbc_pkg;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [2:0] REG_ENABLE        = 3'd0;
  localparam logic [2:0] REG_SIDE_MASK     = 3'd1;
  localparam logic [2:0] REG_AVOID_MODE    = 3'd2;
  localparam logic [2:0] REG_DIRECTION     = 3'd3;
  localparam logic [2:0] REG_ACTIVE_LEVELS = 3'd4;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_ACTION  = 2'd1,
    MODE_STOP    = 2'd2,
    MODE_RELEASE = 2'd3
  } mode_e;

  typedef struct packed {
    logic [2:0] front_sensors;
    logic [2:0] rear_sensors;
  } in_t;

  typedef struct packed {
    logic brake_pulse;
    logic release_pulse;
    logic end_move_pulse;
    logic obstacle_latched;
    logic obstacle_seen;
  } out_t;

  typedef struct packed {
    logic       enable;
    logic [2:0] side_mask;
    mode_e      avoid_mode;
    logic       direction;
    logic [5:0] active_levels;
  } cfg_t;

endpackage

[rtl/odbc_cfg.sv]
module odbc_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [odbc_pkg::ADDR_W-1:0] paddr,
  input  logic [odbc_pkg::DATA_W-1:0] pwdata,
  output logic [odbc_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output odbc_pkg::cfg_t              cfg_o
);

  odbc_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx    = paddr[odbc_pkg::ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        odbc_pkg::REG_ENABLE:        cfg_d.enable        = pwdata[0];
        odbc_pkg::REG_SIDE_MASK:     cfg_d.side_mask     = pwdata[2:0];
        odbc_pkg::REG_AVOID_MODE:    cfg_d.avoid_mode    = odbc_pkg::mode_e'(pwdata[1:0]);
        odbc_pkg::REG_DIRECTION:     cfg_d.direction     = pwdata[0];
        odbc_pkg::REG_ACTIVE_LEVELS: cfg_d.active_levels = pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      odbc_pkg::REG_ENABLE:        prdata[0]   = cfg_q.enable;
      odbc_pkg::REG_SIDE_MASK:     prdata[2:0] = cfg_q.side_mask;
      odbc_pkg::REG_AVOID_MODE:    prdata[1:0] = cfg_q.avoid_mode;
      odbc_pkg::REG_DIRECTION:     prdata[0]   = cfg_q.direction;
      odbc_pkg::REG_ACTIVE_LEVELS: prdata[5:0] = cfg_q.active_levels;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable        <= 1'b1;
      cfg_q.side_mask     <= 3'b111;
      cfg_q.avoid_mode    <= odbc_pkg::MODE_NORMAL;
      cfg_q.direction     <= 1'b0;
      cfg_q.active_levels <= 6'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/odbc_fsm.sv]
`include "obstacle_detect_brake_controller_macros.svh"

module odbc_fsm #(
  parameter int unsigned FILTER_TICKS     = 7,
  parameter int unsigned STOP_HOLD_TICKS  = 20,
  parameter int unsigned AVOID_HOLD_TICKS = 40
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           advance_i,
  input  odbc_pkg::in_t  item_i,
  input  odbc_pkg::cfg_t cfg_i,
  output odbc_pkg::out_t result_o
);

  localparam int unsigned HoldMax = (STOP_HOLD_TICKS > AVOID_HOLD_TICKS) ?
                                    STOP_HOLD_TICKS : AVOID_HOLD_TICKS;
  localparam int unsigned FW = $clog2(FILTER_TICKS + 1);
  localparam int unsigned HW = $clog2(HoldMax + 2);

  logic [FW-1:0] filt_q, filt_d;
  logic [HW-1:0] hold_q, hold_d, hold_inc;
  logic          avs_q, avs_d;
  logic          det_q, det_d;

  logic [2:0] lev, act;
  logic       seen, brake, rel, endmove;

  assign lev      = cfg_i.direction ? item_i.rear_sensors : item_i.front_sensors;
  assign act      = cfg_i.direction ? cfg_i.active_levels[5:3] : cfg_i.active_levels[2:0];
  assign seen     = |(~(lev ^ act) & cfg_i.side_mask);
  assign hold_inc = hold_q + HW'(1);

  always_comb begin
    filt_d  = filt_q;
    hold_d  = hold_q;
    avs_d   = avs_q;
    det_d   = det_q;
    brake   = 1'b0;
    rel     = 1'b0;
    endmove = 1'b0;
    if (cfg_i.enable) begin
      if (seen && !det_q && (filt_q < FW'(FILTER_TICKS))) begin
        filt_d = filt_q + FW'(1);
      end else if (seen && !det_q) begin
        hold_d = '0;
        avs_d  = 1'b0;
        det_d  = 1'b1;
        brake  = 1'b1;
      end else if (det_q) begin
        case (cfg_i.avoid_mode) inside
          odbc_pkg::MODE_STOP: begin
            if (hold_inc > HW'(STOP_HOLD_TICKS)) begin
              hold_d = HW'(STOP_HOLD_TICKS);
              if (!seen) begin
                det_d  = 1'b0;
                filt_d = '0;
                rel    = 1'b1;
              end
            end else begin
              hold_d = hold_inc;
            end
          end
          odbc_pkg::MODE_NORMAL, odbc_pkg::MODE_ACTION: begin
            if (!avs_q) begin
              if (hold_inc > HW'(AVOID_HOLD_TICKS)) begin
                avs_d   = 1'b1;
                hold_d  = '0;
                filt_d  = '0;
                endmove = 1'b1;
              end else begin
                hold_d = hold_inc;
              end
            end
          end
          default: begin
            det_d  = 1'b0;
            filt_d = '0;
            rel    = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q <= '0;
      hold_q <= '0;
      avs_q  <= 1'b0;
      det_q  <= 1'b0;
    end else if (advance_i) begin
      filt_q <= filt_d;
      hold_q <= hold_d;
      avs_q  <= avs_d;
      det_q  <= det_d;
    end
  end

  assign result_o.brake_pulse      = brake;
  assign result_o.release_pulse    = rel;
  assign result_o.end_move_pulse   = endmove;
  assign result_o.obstacle_latched = det_d;
  assign result_o.obstacle_seen    = seen;

  `ODBC_ASSERT(a_one_pulse, $onehot0({brake, rel, endmove}), "more than one pulse in a tick")
  `ODBC_ASSERT(a_filt_range, filt_q <= FW'(FILTER_TICKS), "filter count out of range")
  `ODBC_ASSERT(a_hold_range, hold_q <= HW'(HoldMax), "hold count out of range")
  `ODBC_ASSERT_NEXT(a_brake_latch, advance_i && brake, det_q && !avs_q && hold_q == '0,
                    "brake did not latch detection")
  `ODBC_ASSERT_NEXT(a_frozen, advance_i && !cfg_i.enable,
                    $stable(det_q) && $stable(filt_q) && $stable(hold_q),
                    "state moved while disabled")

endmodule

[rtl/obstacle_detect_brake_controller.sv]
// Obstacle detect and brake controller. One tick of sensor levels per transaction
// and exactly one result per tick; a tick can be accepted every clock cycle, and its
// result passes through the input register and then the result register, with the
// state update in between. Throughput is limited only by out_stall_i. Configuration
// is written over the APB port (byte addresses 0 to 16) and must only change while
// no transaction is in flight.
module obstacle_detect_brake_controller #(
  parameter int unsigned FILTER_TICKS     = 7,
  parameter int unsigned STOP_HOLD_TICKS  = 20,
  parameter int unsigned AVOID_HOLD_TICKS = 40
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  odbc_pkg::in_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output odbc_pkg::out_t              out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [odbc_pkg::ADDR_W-1:0] paddr,
  input  logic [odbc_pkg::DATA_W-1:0] pwdata,
  output logic [odbc_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  odbc_pkg::cfg_t cfg;
  odbc_pkg::in_t  item_q;
  odbc_pkg::out_t res, res_q;
  logic           item_vld_q, item_vld_d;
  logic           out_vld_q, out_vld_d;
  logic           adv, accept;

  assign adv        = item_vld_q & (~out_vld_q | ~out_stall_i);
  assign in_stall_o = item_vld_q & ~adv;
  assign accept     = in_valid_i & ~in_stall_o;
  assign item_vld_d = accept | (item_vld_q & ~adv);
  assign out_vld_d  = adv | (out_vld_q & out_stall_i);

  odbc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  odbc_fsm #(
    .FILTER_TICKS     (FILTER_TICKS),
    .STOP_HOLD_TICKS  (STOP_HOLD_TICKS),
    .AVOID_HOLD_TICKS (AVOID_HOLD_TICKS)
  ) u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (adv),
    .item_i    (item_q),
    .cfg_i     (cfg),
    .result_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      item_vld_q <= item_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
    if (adv) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = res_q;

endmodule

[tb/sv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FILTER_TICKS     = 7;
  localparam int unsigned STOP_HOLD_TICKS  = 20;
  localparam int unsigned AVOID_HOLD_TICKS = 40;
  localparam logic [2:0]  REG_NONE         = 3'd7;
  localparam int unsigned CYCLE_LIMIT      = 800000;
  localparam int unsigned PHASES           = 11;

  // Predicts one result per tick and checks results in order.
  class brake_scoreboard;
    logic           en;
    logic [2:0]     side_mask;
    odbc_pkg::mode_e mode;
    logic           dir;
    logic [5:0]     levels;
    int unsigned    filter_cnt;
    int unsigned    hold_cnt;
    bit             avoid_done;
    bit             latched;
    odbc_pkg::out_t expected_q[$];
    int             errors;

    function new();
      en         = 1'b1;
      side_mask  = 3'b111;
      mode       = odbc_pkg::MODE_NORMAL;
      dir        = 1'b0;
      levels     = '0;
      filter_cnt = 0;
      hold_cnt   = 0;
      avoid_done = 0;
      latched    = 0;
      errors     = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        odbc_pkg::REG_ENABLE:        en = val[0];
        odbc_pkg::REG_SIDE_MASK:     side_mask = val[2:0];
        odbc_pkg::REG_AVOID_MODE:    mode = odbc_pkg::mode_e'(val[1:0]);
        odbc_pkg::REG_DIRECTION:     dir = val[0];
        odbc_pkg::REG_ACTIVE_LEVELS: levels = val[5:0];
        default: ;
      endcase
    endfunction

    function bit sees(odbc_pkg::in_t t);
      logic [2:0] lev;
      logic [2:0] act;
      lev = dir ? t.rear_sensors : t.front_sensors;
      act = dir ? levels[5:3] : levels[2:0];
      return ((~(lev ^ act)) & side_mask) != 3'b000;
    endfunction

    function void note_tick(odbc_pkg::in_t t);
      bit             s;
      odbc_pkg::out_t r;
      s = sees(t);
      r = '0;
      if (en) begin
        if (s && !latched && filter_cnt < FILTER_TICKS) begin
          filter_cnt++;
        end else if (s && !latched) begin
          hold_cnt      = 0;
          avoid_done    = 0;
          latched       = 1;
          r.brake_pulse = 1'b1;
        end else if (latched && mode == odbc_pkg::MODE_STOP) begin
          hold_cnt++;
          if (hold_cnt > STOP_HOLD_TICKS) begin
            hold_cnt = STOP_HOLD_TICKS;
            if (!s) begin
              latched         = 0;
              filter_cnt      = 0;
              r.release_pulse = 1'b1;
            end
          end
        end else if (latched && (mode == odbc_pkg::MODE_ACTION ||
                                 mode == odbc_pkg::MODE_NORMAL)) begin
          if (!avoid_done) begin
            hold_cnt++;
            if (hold_cnt > AVOID_HOLD_TICKS) begin
              avoid_done       = 1;
              hold_cnt         = 0;
              filter_cnt       = 0;
              r.end_move_pulse = 1'b1;
            end
          end
        end else if (latched) begin
          latched         = 0;
          filter_cnt      = 0;
          r.release_pulse = 1'b1;
        end
      end
      r.obstacle_latched = latched;
      r.obstacle_seen    = s;
      expected_q.push_back(r);
    endfunction

    function void check_result(odbc_pkg::out_t got);
      odbc_pkg::out_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: brake=%0b release=%0b end_move=%0b latched=%0b seen=%0b",
                   got.brake_pulse, got.release_pulse, got.end_move_pulse,
                   got.obstacle_latched, got.obstacle_seen);
        return;
      end
      want = expected_q.pop_front();
      if (got.brake_pulse !== want.brake_pulse || got.release_pulse !== want.release_pulse ||
          got.end_move_pulse !== want.end_move_pulse ||
          got.obstacle_latched !== want.obstacle_latched ||
          got.obstacle_seen !== want.obstacle_seen) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected brake=%0b release=%0b end_move=%0b latched=%0b seen=%0b",
                   want.brake_pulse, want.release_pulse, want.end_move_pulse,
                   want.obstacle_latched, want.obstacle_seen,
                   ", got brake=%0b release=%0b end_move=%0b latched=%0b seen=%0b",
                   got.brake_pulse, got.release_pulse, got.end_move_pulse,
                   got.obstacle_latched, got.obstacle_seen);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  odbc_pkg::in_t               in_data_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  odbc_pkg::out_t              out_data_o;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [odbc_pkg::ADDR_W-1:0] paddr;
  logic [odbc_pkg::DATA_W-1:0] pwdata;
  logic [odbc_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  brake_scoreboard sb;
  bit              calm;
  int              stall_left;
  int unsigned     cycles;

  obstacle_detect_brake_controller DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    calm        = 1'b0;
    stall_left  = 0;
    cycles      = 0;
    sb          = new();
  end

  always #6 clk_i = ~clk_i;

  // mostly short gaps, a few long ones
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 70);
  endfunction

  function logic [31:0] noisy(int unsigned w, logic [31:0] val);
    if ($urandom_range(0, 2) == 0) return (32'($urandom) << w) | val;
    return val;
  endfunction

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[obstacle_detect_brake_controller] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(out_data_o);
  end

  always @(negedge clk_i) begin
    int n;
    if (calm) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      n = pick_gap();
      out_stall_i <= (n != 0);
      stall_left = (n > 0) ? n - 1 : 0;
    end
  end

  task automatic send_tick(odbc_pkg::in_t t);
    int gap;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_tick(t);
    gap = calm ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  task automatic apb_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // drain all results, then let the pipeline empty
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // kind 0: qualified sighting, 1: clear view, else raw noise
  function odbc_pkg::in_t make_tick(int kind);
    logic [2:0]    act;
    logic [2:0]    lev;
    logic [2:0]    other;
    int            b;
    odbc_pkg::in_t t;
    act   = sb.dir ? sb.levels[5:3] : sb.levels[2:0];
    other = 3'($urandom);
    lev   = 3'($urandom);
    if (kind == 0 && sb.side_mask != 3'b000) begin
      do b = $urandom_range(0, 2); while (!sb.side_mask[b]);
      lev[b] = act[b];
    end else if (kind == 1) begin
      lev = (~act & sb.side_mask) | (3'($urandom) & ~sb.side_mask);
    end
    if (sb.dir) begin
      t.front_sensors = other;
      t.rear_sensors  = lev;
    end else begin
      t.front_sensors = lev;
      t.rear_sensors  = other;
    end
    return t;
  endfunction

  task automatic set_config(int p);
    logic       en;
    logic [2:0] mask;
    logic [1:0] mode;
    logic       dir;
    logic [5:0] lv;
    en   = (p == 3 || $urandom_range(0, 7) == 0) ? 1'b0 : 1'b1;
    mask = 3'($urandom);
    mode = 2'($urandom);
    dir  = 1'($urandom);
    lv   = 6'($urandom);
    case (p)
      0: begin mask = 3'b111; lv = 6'h3F; mode = odbc_pkg::MODE_STOP;    dir = 1'b0; end
      1: begin mask = 3'b000; lv = 6'h00; mode = odbc_pkg::MODE_ACTION;  dir = 1'b1; end
      2: begin mask = 3'b001; lv = 6'h00; mode = odbc_pkg::MODE_RELEASE; dir = 1'b0; end
      4: begin mask = 3'b100; lv = 6'h3F; mode = odbc_pkg::MODE_NORMAL;  dir = 1'b1; end
      5: begin mask = 3'b010; lv = 6'h2A; mode = odbc_pkg::MODE_STOP;    dir = 1'b1; end
      default: ;
    endcase
    apb_write(odbc_pkg::REG_SIDE_MASK, noisy(3, 32'(mask)));
    apb_write(odbc_pkg::REG_AVOID_MODE, noisy(2, 32'(mode)));
    apb_write(odbc_pkg::REG_DIRECTION, noisy(1, 32'(dir)));
    apb_write(odbc_pkg::REG_ACTIVE_LEVELS, noisy(6, 32'(lv)));
    apb_write(odbc_pkg::REG_ENABLE, noisy(1, 32'(en)));
    if ($urandom_range(0, 3) == 0)
      apb_write(REG_NONE, $urandom);
  endtask

  task automatic run_phase(int n);
    int sent;
    int len;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 99) < 75) begin
        len = $urandom_range(1, 60);
        repeat (len) send_tick(make_tick(($urandom_range(0, 19) == 0) ? 2 : 0));
        sent += len;
        len = $urandom_range(1, 30);
        repeat (len) send_tick(make_tick(($urandom_range(0, 19) == 0) ? 2 : 1));
        sent += len;
      end else begin
        len = $urandom_range(1, 8);
        repeat (len) send_tick(make_tick(2));
        sent += len;
      end
    end
  endtask

  initial begin
    odbc_pkg::in_t t;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes under reset config, then reverse, disabled and release mode
    for (int v = 0; v < 8; v++) begin
      t.front_sensors = 3'(v);
      t.rear_sensors  = 3'(7 - v);
      send_tick(t);
    end
    t = '0;           send_tick(t);
    t = '1;           send_tick(t);
    t = {3'd0, 3'd7}; send_tick(t);
    t = {3'd7, 3'd0}; send_tick(t);
    settle();
    apb_write(odbc_pkg::REG_DIRECTION, 32'd1);
    t = {3'd0, 3'd7}; send_tick(t);
    t = {3'd7, 3'd0}; send_tick(t);
    t = {3'd2, 3'd5}; send_tick(t);
    settle();
    apb_write(odbc_pkg::REG_ENABLE, 32'd0);
    t = '0; send_tick(t);
    t = '1; send_tick(t);
    settle();
    apb_write(odbc_pkg::REG_ENABLE, 32'd1);
    apb_write(odbc_pkg::REG_AVOID_MODE, 32'(odbc_pkg::MODE_RELEASE));
    t = '1; send_tick(t);
    t = '0; send_tick(t);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      set_config(p);
      calm = ($urandom_range(0, 3) == 0);
      run_phase($urandom_range(80, 120));
      settle();
      calm = 1'b0;
    end

    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[obstacle_detect_brake_controller] OK");
    end else begin
      $display("[obstacle_detect_brake_controller] ERROR");
    end
    $finish;
  end

endmodule
